// File: design/lasc_pkg.sv
// ----------------------------------------------------------------------------
// lasc_pkg
// Shared types and constants of the local alignment scorer: operation codes,
// traceback direction codes, scoring constants and sequencer states.
// ----------------------------------------------------------------------------
package lasc_pkg;

  localparam logic [1:0] OP_ROW = 2'd0;
  localparam logic [1:0] OP_COL = 2'd1;
  localparam logic [1:0] OP_RUN = 2'd2;

  localparam int SCORE_MATCH    = 2;
  localparam int SCORE_MISMATCH = -1;
  localparam int SCORE_GAP      = -2;

  localparam int MAX_RES = 64;

  typedef enum logic [1:0] {
    DIR_DIAG = 2'd0,
    DIR_UP   = 2'd1,
    DIR_LEFT = 2'd2,
    DIR_ZERO = 2'd3
  } dir_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL_RD,
    ST_FILL_CALC,
    ST_TB_INIT,
    ST_TB_RD,
    ST_TB_STEP,
    ST_EMIT_RD,
    ST_EMIT_LOAD,
    ST_EMIT_WAIT
  } state_t;

endpackage

// File: design/lasc_item_if.sv
// ----------------------------------------------------------------------------
// lasc_item_if
// Input channel of the local alignment scorer: operation and symbol.
// ----------------------------------------------------------------------------
interface lasc_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] symbol;

  modport source (output valid, op, symbol, input ready);
  modport sink   (input valid, op, symbol, output ready);
endinterface

// File: design/lasc_result_if.sv
// ----------------------------------------------------------------------------
// lasc_result_if
// Result channel of the local alignment scorer: one aligned symbol per
// transaction with the score and end position of the run.
// ----------------------------------------------------------------------------
interface lasc_result_if;
  logic       valid;
  logic       ready;
  logic       aligned_valid;
  logic [7:0] aligned_symbol;
  logic [7:0] best_score;
  logic [6:0] end_row;
  logic [6:0] end_col;
  logic       overflow;
  logic       last;

  modport source (output valid, aligned_valid, aligned_symbol, best_score, end_row,
                  end_col, overflow, last, input ready);
  modport sink   (input valid, aligned_valid, aligned_symbol, best_score, end_row,
                  end_col, overflow, last, output ready);
endinterface

// File: design/local_alignment_scorer.sv
// ----------------------------------------------------------------------------
// local_alignment_scorer
// Smith-Waterman local alignment (match +2, mismatch -1, gap -2) over a row
// and a column string, with traceback of the best cell.
// Append: one transaction per cycle while idle. Run: each grid cell (R*C)
// takes a read and a calc state, each traceback step a read and a step state
// after the init state, and each result a read, load and wait state, held
// while the sink stalls; the single shared cell unit behind registered memory reads sets this.
// Reset: lengths, overflow and best cell cleared; string and direction
// memories hold no defined value until written.
// ----------------------------------------------------------------------------
module local_alignment_scorer
  import lasc_pkg::*;
#(
  parameter int MAX_LEN = 64
) (
  input  logic          clk,
  input  logic          rst,
  lasc_item_if.sink     item,
  lasc_result_if.source result
);

  localparam int AW    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int LW    = $clog2(MAX_LEN + 1);
  localparam int SW    = $clog2(2 * MAX_LEN + 1);
  localparam int DEPTH = MAX_LEN * MAX_LEN;
  localparam int DW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int XW    = (SW > 8) ? SW : 9;
  localparam int PW    = (LW > 7) ? LW : 7;
  localparam int KW    = PW + 1;

  state_t state, state_next;

  logic [LW-1:0] row_length;
  logic [LW-1:0] col_length;
  logic          overflow_flag;

  logic [7:0]    row_mem  [MAX_LEN];
  logic [7:0]    col_mem  [MAX_LEN];
  logic [SW-1:0] prev_mem [MAX_LEN];
  dir_t          dir_mem  [DEPTH];
  logic [7:0]    tbuf_mem [MAX_LEN];

  logic [7:0]    row_q;
  logic [7:0]    col_q;
  logic [SW-1:0] prev_q;
  dir_t          dir_q;
  logic [7:0]    tbuf_q;

  logic [LW-1:0] row_sel;
  logic [AW-1:0] row_raddr;
  logic [AW-1:0] col_raddr;
  logic [AW-1:0] tbuf_raddr;
  logic [LW-1:0] tbuf_diff;

  logic [LW-1:0] fill_i;
  logic [LW-1:0] fill_j;
  logic [DW-1:0] row_base;
  logic [DW-1:0] cell_addr;
  logic [SW-1:0] diag_score;
  logic [SW-1:0] left_score;
  logic [SW-1:0] up_score;
  logic [SW-1:0] cell_val;
  dir_t          cell_dir;
  logic          sym_match;

  logic [SW-1:0] best_value;
  logic [LW-1:0] best_row;
  logic [LW-1:0] best_col;
  logic [DW-1:0] best_addr;

  logic [LW-1:0] tb_i;
  logic [LW-1:0] tb_j;
  logic [DW-1:0] tb_addr;
  logic [LW-1:0] tb_count;
  logic [LW-1:0] emit_k;

  logic          item_fire;
  logic          result_fire;
  logic [KW-1:0] emit_k1;
  logic          emit_last;
  logic [XW-1:0] best_ext;
  logic [7:0]    best_sat;
  logic [PW-1:0] row_ext;
  logic [PW-1:0] col_ext;

  assign item_fire   = item.valid && item.ready;
  assign result_fire = result.valid && result.ready;

  // address selection
  assign row_sel    = (state == ST_TB_RD) ? tb_i : fill_i;
  assign row_raddr  = AW'(row_sel - LW'(1));
  assign col_raddr  = AW'(fill_j - LW'(1));
  assign tbuf_diff  = tb_count - LW'(1) - emit_k;
  assign tbuf_raddr = AW'(tbuf_diff);

  assign up_score  = (fill_i == LW'(1)) ? '0 : prev_q;
  assign sym_match = (row_q == col_q);

  lasc_cell #(.SW(SW)) u_cell (
    .diag (diag_score),
    .up   (up_score),
    .left (left_score),
    .eq   (sym_match),
    .val  (cell_val),
    .dir  (cell_dir)
  );

  assign emit_k1   = KW'(emit_k) + KW'(1);
  assign emit_last = (tb_count == '0) || (emit_k1 == KW'(tb_count)) ||
                     (emit_k1 == KW'(MAX_RES));
  assign best_ext  = XW'(best_value);
  assign best_sat  = (best_ext > XW'(255)) ? 8'hFF : best_ext[7:0];
  assign row_ext   = PW'(best_row);
  assign col_ext   = PW'(best_col);

  // memories
  always_ff @(posedge clk) begin
    if (item_fire && item.op == OP_ROW && row_length < LW'(MAX_LEN)) begin
      row_mem[AW'(row_length)] <= item.symbol;
    end
    row_q <= row_mem[row_raddr];
  end

  always_ff @(posedge clk) begin
    if (item_fire && item.op == OP_COL && col_length < LW'(MAX_LEN)) begin
      col_mem[AW'(col_length)] <= item.symbol;
    end
    col_q <= col_mem[col_raddr];
  end

  always_ff @(posedge clk) begin
    if (state == ST_FILL_CALC) begin
      prev_mem[col_raddr] <= cell_val;
    end
    prev_q <= prev_mem[col_raddr];
  end

  always_ff @(posedge clk) begin
    if (state == ST_FILL_CALC) begin
      dir_mem[cell_addr] <= cell_dir;
    end
    dir_q <= dir_mem[tb_addr];
  end

  always_ff @(posedge clk) begin
    if (state == ST_TB_STEP && dir_q == DIR_DIAG && tb_count < LW'(MAX_LEN)) begin
      tbuf_mem[AW'(tb_count)] <= row_q;
    end
    tbuf_q <= tbuf_mem[tbuf_raddr];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    item.ready   = 1'b0;
    result.valid = 1'b0;
    unique case (state)
      ST_IDLE: begin
        item.ready = 1'b1;
        if (item.valid && item.op == OP_RUN) begin
          if (row_length == '0 || col_length == '0) begin
            state_next = ST_TB_INIT;
          end else begin
            state_next = ST_FILL_RD;
          end
        end
      end
      ST_FILL_RD: state_next = ST_FILL_CALC;
      ST_FILL_CALC: begin
        if (fill_j == col_length && fill_i == row_length) begin
          state_next = ST_TB_INIT;
        end else begin
          state_next = ST_FILL_RD;
        end
      end
      ST_TB_INIT: state_next = ST_TB_RD;
      ST_TB_RD: begin
        if (tb_i == '0 || tb_j == '0) begin
          state_next = ST_EMIT_RD;
        end else begin
          state_next = ST_TB_STEP;
        end
      end
      ST_TB_STEP: begin
        if (dir_q == DIR_ZERO) begin
          state_next = ST_EMIT_RD;
        end else begin
          state_next = ST_TB_RD;
        end
      end
      ST_EMIT_RD:   state_next = ST_EMIT_LOAD;
      ST_EMIT_LOAD: state_next = ST_EMIT_WAIT;
      ST_EMIT_WAIT: begin
        result.valid = 1'b1;
        if (result.ready) begin
          state_next = result.last ? ST_IDLE : ST_EMIT_RD;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      row_length    <= '0;
      col_length    <= '0;
      overflow_flag <= 1'b0;
      best_value    <= '0;
      best_row      <= '0;
      best_col      <= '0;
      tb_count      <= '0;
      emit_k        <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (item_fire) begin
            unique case (item.op)
              OP_ROW: begin
                if (row_length < LW'(MAX_LEN)) begin
                  row_length <= row_length + LW'(1);
                end else begin
                  overflow_flag <= 1'b1;
                end
              end
              OP_COL: begin
                if (col_length < LW'(MAX_LEN)) begin
                  col_length <= col_length + LW'(1);
                end else begin
                  overflow_flag <= 1'b1;
                end
              end
              OP_RUN: begin
                best_value <= '0;
                best_row   <= '0;
                best_col   <= '0;
                best_addr  <= '0;
                tb_count   <= '0;
                fill_i     <= LW'(1);
                fill_j     <= LW'(1);
                diag_score <= '0;
                left_score <= '0;
                row_base   <= '0;
                cell_addr  <= '0;
              end
              default: ;
            endcase
          end
        end
        ST_FILL_CALC: begin
          if (cell_val > best_value) begin
            best_value <= cell_val;
            best_row   <= fill_i;
            best_col   <= fill_j;
            best_addr  <= cell_addr;
          end
          if (fill_j == col_length) begin
            fill_i     <= fill_i + LW'(1);
            fill_j     <= LW'(1);
            diag_score <= '0;
            left_score <= '0;
            row_base   <= row_base + DW'(MAX_LEN);
            cell_addr  <= row_base + DW'(MAX_LEN);
          end else begin
            fill_j     <= fill_j + LW'(1);
            cell_addr  <= cell_addr + DW'(1);
            diag_score <= up_score;
            left_score <= cell_val;
          end
        end
        ST_TB_INIT: begin
          tb_i     <= best_row;
          tb_j     <= best_col;
          tb_addr  <= best_addr;
          tb_count <= '0;
          emit_k   <= '0;
        end
        ST_TB_STEP: begin
          unique case (dir_q)
            DIR_DIAG: begin
              if (tb_count < LW'(MAX_LEN)) begin
                tb_count <= tb_count + LW'(1);
              end
              tb_i    <= tb_i - LW'(1);
              tb_j    <= tb_j - LW'(1);
              tb_addr <= tb_addr - DW'(MAX_LEN + 1);
            end
            DIR_UP: begin
              tb_i    <= tb_i - LW'(1);
              tb_addr <= tb_addr - DW'(MAX_LEN);
            end
            DIR_LEFT: begin
              tb_j    <= tb_j - LW'(1);
              tb_addr <= tb_addr - DW'(1);
            end
            default: ;
          endcase
        end
        ST_EMIT_LOAD: begin
          result.aligned_valid  <= (tb_count != '0);
          result.aligned_symbol <= (tb_count != '0) ? tbuf_q : 8'h00;
          result.best_score     <= best_sat;
          result.end_row        <= row_ext[6:0];
          result.end_col        <= col_ext[6:0];
          result.overflow       <= overflow_flag;
          result.last           <= emit_last;
        end
        ST_EMIT_WAIT: begin
          if (result.ready) begin
            if (result.last) begin
              row_length    <= '0;
              col_length    <= '0;
              overflow_flag <= 1'b0;
            end else begin
              emit_k <= emit_k + LW'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  // checks
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(result.valid && item.ready))
    else $error("input taken while a result transaction is pending");

  a_best_pos: assert property (@(posedge clk) disable iff (rst)
    (state == ST_TB_INIT && best_value != '0) |-> (best_row != '0 && best_col != '0))
    else $error("nonzero best score without an end position");

  a_trace_len: assert property (@(posedge clk) disable iff (rst)
    tb_count <= best_row)
    else $error("traceback longer than best row");

  a_run_clear: assert property (@(posedge clk) disable iff (rst)
    (result_fire && result.last) |=> (row_length == '0 && col_length == '0 && item.ready))
    else $error("lengths not cleared after final result");

endmodule

// File: design/lasc_cell.sv
// ----------------------------------------------------------------------------
// lasc_cell
// Shared cell unit: one Smith-Waterman cell with linear gap, floored at zero,
// and its traceback direction (diagonal, then up, then left on ties).
// ----------------------------------------------------------------------------
module lasc_cell
  import lasc_pkg::*;
#(
  parameter int SW = 8
) (
  input  logic [SW-1:0] diag,
  input  logic [SW-1:0] up,
  input  logic [SW-1:0] left,
  input  logic          eq,
  output logic [SW-1:0] val,
  output dir_t          dir
);

  localparam int CW = SW + 2;
  localparam logic signed [CW-1:0] K_MATCH    = CW'(SCORE_MATCH);
  localparam logic signed [CW-1:0] K_MISMATCH = CW'(SCORE_MISMATCH);
  localparam logic signed [CW-1:0] K_GAP      = CW'(SCORE_GAP);

  logic signed [CW-1:0] m;
  logic signed [CW-1:0] g1;
  logic signed [CW-1:0] g2;
  logic signed [CW-1:0] v;

  always_comb begin
    m  = signed'({2'b00, diag}) + (eq ? K_MATCH : K_MISMATCH);
    g1 = signed'({2'b00, up}) + K_GAP;
    g2 = signed'({2'b00, left}) + K_GAP;
    if (m > g1 && m > g2) begin
      v = m;
    end else if (g1 > g2) begin
      v = g1;
    end else begin
      v = g2;
    end
    if (v < 0) begin
      v = '0;
    end
    val = v[SW-1:0];
    priority if (v == 0) begin
      dir = DIR_ZERO;
    end else if (v == m) begin
      dir = DIR_DIAG;
    end else if (v == g1) begin
      dir = DIR_UP;
    end else begin
      dir = DIR_LEFT;
    end
  end

endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for local_alignment_scorer. A directed table walks the
// empty, mismatch, gap and overflow cases. Random append/run
// sequences over small alphabets follow. Every accepted transaction feeds a
// scoring and traceback predictor, and each result transaction is compared
// field by field with the oldest awaited result. Both channels idle in random
// bursts.
// ----------------------------------------------------------------------------
module testbench
  import lasc_pkg::*;
();

  localparam int MAX_LEN      = 64;
  localparam int RANDOM_ITEMS = 60;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE       = 50;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic       aligned_valid;
    logic [7:0] aligned_symbol;
    logic [7:0] best_score;
    logic [6:0] end_row;
    logic [6:0] end_col;
    logic       overflow;
    logic       last;
  } trace_result_t;

  typedef struct packed {
    logic [1:0]    op;
    logic [7:0]    symbol;
    logic [6:0]    reps;
    logic          typed;
    trace_result_t want;
  } stim_row_t;

  localparam trace_result_t EMPTY_RUN = '{1'b0, 8'h00, 8'd0, 7'd0, 7'd0, 1'b0, 1'b1};

  stim_row_t directed_rows [22] = '{
    '{OP_RUN,    8'h00, 7'd1,  1'b1, EMPTY_RUN},
    '{OP_UNUSED, 8'hFF, 7'd1,  1'b0, '0},
    '{OP_ROW,    8'h41, 7'd1,  1'b0, '0},
    '{OP_COL,    8'h41, 7'd1,  1'b0, '0},
    '{OP_RUN,    8'h00, 7'd1,  1'b1, '{1'b1, 8'h41, 8'd2, 7'd1, 7'd1, 1'b0, 1'b1}},
    '{OP_ROW,    8'h00, 7'd1,  1'b0, '0},
    '{OP_COL,    8'hFF, 7'd1,  1'b0, '0},
    '{OP_RUN,    8'hFF, 7'd1,  1'b1, EMPTY_RUN},
    '{OP_ROW,    8'hFF, 7'd1,  1'b0, '0},
    '{OP_COL,    8'hFF, 7'd1,  1'b0, '0},
    '{OP_RUN,    8'h00, 7'd1,  1'b1, '{1'b1, 8'hFF, 8'd2, 7'd1, 7'd1, 1'b0, 1'b1}},
    '{OP_ROW,    8'h10, 7'd5,  1'b0, '0},
    '{OP_COL,    8'h10, 7'd2,  1'b0, '0},
    '{OP_COL,    8'h13, 7'd2,  1'b0, '0},
    '{OP_RUN,    8'h00, 7'd1,  1'b0, '0},
    '{OP_ROW,    8'h20, 7'd2,  1'b0, '0},
    '{OP_ROW,    8'h23, 7'd2,  1'b0, '0},
    '{OP_COL,    8'h20, 7'd4,  1'b0, '0},
    '{OP_RUN,    8'h00, 7'd1,  1'b0, '0},
    '{OP_COL,    8'h00, 7'd65, 1'b0, '0},
    '{OP_RUN,    8'h00, 7'd1,  1'b1, '{1'b0, 8'h00, 8'd0, 7'd0, 7'd0, 1'b1, 1'b1}},
    '{OP_UNUSED, 8'h5A, 7'd1,  1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst;

  lasc_item_if   item ();
  lasc_result_if result ();

  local_alignment_scorer #(.MAX_LEN(MAX_LEN)) u_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .result (result)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state
  logic [7:0]    row_seq [MAX_LEN];
  logic [7:0]    col_seq [MAX_LEN];
  int            row_len;
  int            col_len;
  logic          dropped;
  dir_t          dir_grid [MAX_LEN][MAX_LEN];
  trace_result_t run_results [$];
  trace_result_t traceback_q [$];

  int  errors;
  int  cycles;
  int  items_sent;
  int  runs_sent;
  int  results_checked;
  int  deepest_trace;
  bit  calm;

  task automatic report_error(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want) report_error($sformatf("%s is %0h, wanted %0h", name, got, want));
  endtask

  function automatic void align_strings();
    int            prev_row [MAX_LEN + 1];
    int            diag, left, up, m, g1, g2, v;
    int            best, bi, bj, i, j;
    dir_t          d;
    logic [7:0]    path [$];
    trace_result_t r;
    foreach (prev_row[k]) prev_row[k] = 0;
    best = 0;
    bi = 0;
    bj = 0;
    for (i = 1; i <= row_len; i++) begin
      diag = 0;
      left = 0;
      for (j = 1; j <= col_len; j++) begin
        up = prev_row[j];
        m  = diag + ((row_seq[i-1] == col_seq[j-1]) ? SCORE_MATCH : SCORE_MISMATCH);
        g1 = up + SCORE_GAP;
        g2 = left + SCORE_GAP;
        v  = (m > g1 && m > g2) ? m : ((g1 > g2) ? g1 : g2);
        if (v < 0) v = 0;
        if (v == 0) d = DIR_ZERO;
        else if (v == m) d = DIR_DIAG;
        else if (v == g1) d = DIR_UP;
        else d = DIR_LEFT;
        dir_grid[i-1][j-1] = d;
        diag = up;
        prev_row[j] = v;
        left = v;
        if (v > best) begin
          best = v;
          bi = i;
          bj = j;
        end
      end
    end
    i = bi;
    j = bj;
    while (i > 0 && j > 0) begin
      d = dir_grid[i-1][j-1];
      if (d == DIR_ZERO) break;
      if (d == DIR_DIAG) begin
        path.push_front(row_seq[i-1]);
        i--;
        j--;
      end else if (d == DIR_UP) begin
        i--;
      end else begin
        j--;
      end
    end
    if (path.size() > deepest_trace) deepest_trace = path.size();
    r.best_score = 8'(best);
    r.end_row    = 7'(bi);
    r.end_col    = 7'(bj);
    r.overflow   = dropped;
    if (path.size() == 0) begin
      r.aligned_valid  = 1'b0;
      r.aligned_symbol = 8'h00;
      r.last           = 1'b1;
      run_results.push_back(r);
    end else begin
      foreach (path[k]) begin
        r.aligned_valid  = 1'b1;
        r.aligned_symbol = path[k];
        r.last           = (k == path.size() - 1);
        run_results.push_back(r);
      end
    end
    row_len = 0;
    col_len = 0;
    dropped = 1'b0;
  endfunction

  function automatic void apply_item(input logic [1:0] op, input logic [7:0] sym);
    run_results.delete();
    case (op)
      OP_ROW: begin
        if (row_len < MAX_LEN) begin
          row_seq[row_len] = sym;
          row_len++;
        end else begin
          dropped = 1'b1;
        end
      end
      OP_COL: begin
        if (col_len < MAX_LEN) begin
          col_seq[col_len] = sym;
          col_len++;
        end else begin
          dropped = 1'b1;
        end
      end
      OP_RUN: align_strings();
      default: ;
    endcase
  endfunction

  task automatic send_item(input logic [1:0] op, input logic [7:0] sym,
                           input logic typed, input trace_result_t want);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      item.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item.valid  <= 1'b1;
    item.op     <= op;
    item.symbol <= sym;
    @(posedge clk);
    while (item.ready !== 1'b1) @(posedge clk);
    apply_item(op, sym);
    if (typed) begin
      traceback_q.push_back(want);
    end else begin
      foreach (run_results[k]) traceback_q.push_back(run_results[k]);
    end
    items_sent++;
    if (op == OP_RUN) runs_sent++;
  endtask

  task automatic drain_results();
    item.valid <= 1'b0;
    @(posedge clk);
    while (traceback_q.size() != 0) @(posedge clk);
  endtask

  // result side: random stall bursts
  initial begin
    int hold;
    result.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 9) == 0) begin
        hold = $urandom_range(1, 11);
        result.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      result.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    trace_result_t got;
    trace_result_t want;
    if (rst === 1'b0 && result.valid === 1'b1 && result.ready === 1'b1) begin
      got = {result.aligned_valid, result.aligned_symbol, result.best_score,
             result.end_row, result.end_col, result.overflow, result.last};
      if (traceback_q.size() == 0) begin
        report_error("result transaction with nothing awaited");
      end else begin
        want = traceback_q.pop_front();
        check_field("aligned_valid", 8'(got.aligned_valid), 8'(want.aligned_valid));
        check_field("aligned_symbol", got.aligned_symbol, want.aligned_symbol);
        check_field("best_score", got.best_score, want.best_score);
        check_field("end_row", 8'(got.end_row), 8'(want.end_row));
        check_field("end_col", 8'(got.end_col), 8'(want.end_col));
        check_field("overflow", 8'(got.overflow), 8'(want.overflow));
        check_field("last", 8'(got.last), 8'(want.last));
        results_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout with %0d results still awaited", traceback_q.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int         random_items;
    int         kind;
    int         rl;
    int         cl;
    bit         to_row;
    logic [7:0] sym;
    logic [7:0] alphabet [4];
    errors          = 0;
    cycles          = 0;
    items_sent      = 0;
    runs_sent       = 0;
    results_checked = 0;
    deepest_trace   = 0;
    calm            = 1'b0;
    row_len         = 0;
    col_len         = 0;
    dropped         = 1'b0;
    random_items    = 0;
    rst         <= 1'b1;
    item.valid  <= 1'b0;
    item.op     <= OP_ROW;
    item.symbol <= 8'h00;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[r]) begin
      for (int k = 0; k < directed_rows[r].reps; k++) begin
        send_item(directed_rows[r].op, 8'(directed_rows[r].symbol + k),
                  directed_rows[r].typed, directed_rows[r].want);
      end
    end
    drain_results();

    while (random_items < RANDOM_ITEMS) begin
      if (random_items >= RANDOM_ITEMS - 30) calm = 1'b1;
      foreach (alphabet[s]) alphabet[s] = 8'($urandom);
      kind = $urandom_range(0, 9);
      rl = $urandom_range(1, 8);
      cl = $urandom_range(1, 8);
      if (kind == 9) begin
        rl = $urandom_range(9, 20);
        cl = $urandom_range(9, 20);
      end else if (kind == 0) begin
        // broken sequence: one side left empty, stray unused op
        if ($urandom_range(0, 1) == 1) rl = 0;
        else cl = 0;
        send_item(OP_UNUSED, 8'($urandom), 1'b0, '0);
      end
      if (!calm && $urandom_range(0, 7) == 0) drain_results();
      while (rl + cl > 0) begin
        to_row = (cl == 0) || (rl != 0 && $urandom_range(0, 1) == 1);
        sym = ($urandom_range(0, 7) == 0) ? 8'($urandom) : alphabet[$urandom_range(0, 3)];
        if (to_row) begin
          send_item(OP_ROW, sym, 1'b0, '0);
          rl--;
        end else begin
          send_item(OP_COL, sym, 1'b0, '0);
          cl--;
        end
        random_items++;
      end
      send_item(OP_RUN, 8'($urandom), 1'b0, '0);
      random_items++;
    end

    item.valid <= 1'b0;
    while (traceback_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("Sent %0d transactions in %0d alignment runs, checked %0d result transactions",
             items_sent, runs_sent, results_checked);
    $display("Longest traceback %0d symbols; empty, mismatch, gap and overflow runs included",
             deepest_trace);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
